@@ sv/abm_pkg.sv @@
`timescale 1ns / 1ps
package abm_pkg;

   localparam int HALF_W  = 64;
   localparam int BLOCK_W = 128;
   localparam int ROUNDS  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W  = 4;

   typedef logic [ROUNDS:0][BLOCK_W-1:0] rk_array_type;

   typedef enum logic [1:0] {
      MODE_ECB = 2'd0,
      MODE_CBC = 2'd1,
      MODE_CTR = 2'd2
   } chain_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_HIGH    = 3'd0,
      CSR_KEY_LOW     = 3'd1,
      CSR_IV_HIGH     = 3'd2,
      CSR_IV_LOW      = 3'd3,
      CSR_CHAIN_MODE  = 3'd4,
      CSR_DECRYPT_SEL = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ks_status_type;

   typedef logic [7:0] sbox_tab_type [0:255];

   localparam sbox_tab_type SBOX_TAB = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // inverse table built at elaboration
   function automatic sbox_tab_type build_inv();
      sbox_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[SBOX_TAB[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam sbox_tab_type INV_SBOX_TAB = build_inv();

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // multiply by a small constant in GF(2^8)
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) acc = acc ^ p;
         p = xtime(p);
      end
      return acc;
   endfunction

   function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
      return s[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_shift_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX_TAB[get_byte(s, ((c + r) % 4) * 4 + r)];
         end
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_shift_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[BLOCK_W-1-8*(((c + r) % 4)*4+r) -: 8] = INV_SBOX_TAB[get_byte(s, c*4+r)];
         end
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0, a1, a2, a3;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         o[BLOCK_W-1-8*(c*4)   -: 8] = gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3;
         o[BLOCK_W-1-8*(c*4+1) -: 8] = a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3;
         o[BLOCK_W-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3);
         o[BLOCK_W-1-8*(c*4+3) -: 8] = gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2);
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0, a1, a2, a3;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         o[BLOCK_W-1-8*(c*4)   -: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11)
                                     ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
         o[BLOCK_W-1-8*(c*4+1) -: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14)
                                     ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
         o[BLOCK_W-1-8*(c*4+2) -: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9)
                                     ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
         o[BLOCK_W-1-8*(c*4+3) -: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13)
                                     ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
      end
      return o;
   endfunction

   function automatic logic [7:0] rcon(input logic [STEP_W-1:0] step);
      logic [7:0] v;
      unique case (step)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] k,
                                                         input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX_TAB[w3[23:16]], SBOX_TAB[w3[15:8]], SBOX_TAB[w3[7:0]], SBOX_TAB[w3[31:24]]};
      t  = t ^ {rc, 24'h000000};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

@@ sv/abm_req_if.sv @@
`timescale 1ns / 1ps
interface abm_req_if;
   import abm_pkg::*;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] block_high;
   logic [HALF_W-1:0] block_low;
   logic              first_block;
   modport source (output valid, block_high, block_low, first_block, input ready);
   modport sink   (input valid, block_high, block_low, first_block, output ready);
endinterface

@@ sv/abm_rsp_if.sv @@
`timescale 1ns / 1ps
interface abm_rsp_if;
   import abm_pkg::*;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] result_high;
   logic [HALF_W-1:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink   (input valid, result_high, result_low, output ready);
endinterface

@@ sv/abm_key_sched.sv @@
`timescale 1ns / 1ps
module abm_key_sched (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic [abm_pkg::BLOCK_W-1:0]  key,
   output abm_pkg::rk_array_type        round_keys,
   output abm_pkg::ks_status_type       status
);
   import abm_pkg::*;

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BLOCK_W-1:0] work_ff, work_in;
   rk_array_type       rk_ff, rk_in;
   logic               running;

   assign running = (step_ff <= STEP_W'(ROUNDS));

   // one round key per cycle, shifted in from the top
   always_comb begin
      step_in = step_ff;
      work_in = work_ff;
      rk_in   = rk_ff;
      if (restart) begin
         step_in = '0;
      end else if (running) begin
         step_in = step_ff + STEP_W'(1);
         work_in = (step_ff == '0) ? key : next_round_key(work_ff, rcon(step_ff));
         rk_in   = {work_in, rk_ff[ROUNDS:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rk_ff   <= rk_in;
   end

   assign round_keys  = rk_ff;
   assign status.busy = running || restart;
   assign status.done = (step_ff == STEP_W'(ROUNDS + 1));

endmodule

@@ sv/abm_cipher.sv @@
`timescale 1ns / 1ps
module abm_cipher (
   input  abm_pkg::rk_array_type        round_keys,
   input  logic [abm_pkg::BLOCK_W-1:0]  fwd_in,
   input  logic [abm_pkg::BLOCK_W-1:0]  inv_in,
   output logic [abm_pkg::BLOCK_W-1:0]  fwd_out,
   output logic [abm_pkg::BLOCK_W-1:0]  inv_out
);
   import abm_pkg::*;

   logic [BLOCK_W-1:0] fwd_s [0:ROUNDS];
   logic [BLOCK_W-1:0] inv_s [0:ROUNDS];

   assign fwd_s[0] = fwd_in ^ round_keys[0];
   assign inv_s[0] = inv_in ^ round_keys[ROUNDS];

   for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
      logic [BLOCK_W-1:0] f_ss;
      logic [BLOCK_W-1:0] i_ak;
      assign f_ss = sub_shift_fwd(fwd_s[r-1]);
      assign fwd_s[r] = ((r == ROUNDS) ? f_ss : mix_fwd(f_ss)) ^ round_keys[r];
      // inverse round r uses key ROUNDS - r
      assign i_ak = sub_shift_inv(inv_s[r-1]) ^ round_keys[ROUNDS-r];
      assign inv_s[r] = (r == ROUNDS) ? i_ak : mix_inv(i_ak);
   end

   assign fwd_out = fwd_s[ROUNDS];
   assign inv_out = inv_s[ROUNDS];

endmodule

@@ sv/aes128_block_modes_unit.sv @@
`timescale 1ns / 1ps
// aes-128 in ecb, cbc or ctr mode, one 128-bit word in and one out. a word
// is latched in an input register, passes all ten rounds of combinational
// logic and lands in a result register, so a word can be accepted every
// cycle while the key schedule is idle and the result register is free or
// being drained. the clock rate is set by the unrolled ten-round core.
// after reset and after each write of key_high or key_low the key schedule
// expands, and req_ch.ready is low while it does. cbc chains through the
// previous cipher word, ctr encrypts a 128-bit counter starting at the iv;
// first_block reloads both from the iv. chain_mode 3 acts as ecb.
module aes128_block_modes_unit (
   input  logic                           clock,
   input  logic                           reset,
   abm_req_if.sink                        req_ch,
   abm_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [abm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abm_pkg::HALF_W-1:0]     csr_wdata
);
   import abm_pkg::*;

   // configuration registers
   logic [BLOCK_W-1:0] key_ff;
   logic [BLOCK_W-1:0] iv_ff;
   logic [1:0]         mode_ff;
   logic               dec_ff;
   logic               key_wr;

   // input word register
   logic               in_v_ff;
   logic [BLOCK_W-1:0] in_data_ff;
   logic               in_first_ff;

   // result register
   logic               out_v_ff;
   logic [BLOCK_W-1:0] out_data_ff, out_data_in;

   // chaining state
   logic [BLOCK_W-1:0] chain_ff, chain_in;
   logic [BLOCK_W-1:0] ctr_ff, ctr_in;

   logic               advance;
   logic               take;
   rk_array_type       round_keys;
   ks_status_type      ks_status;
   logic [BLOCK_W-1:0] chain_eff, ctr_eff;
   logic [BLOCK_W-1:0] fwd_in, fwd_out, inv_out;
   logic               is_cbc, is_ctr;

   always_comb begin
      key_wr = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HIGH, CSR_KEY_LOW: key_wr = 1'b1;
            default:                   key_wr = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         iv_ff   <= '0;
         mode_ff <= MODE_ECB;
         dec_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HIGH:    key_ff[127:64] <= csr_wdata;
            CSR_KEY_LOW:     key_ff[63:0]   <= csr_wdata;
            CSR_IV_HIGH:     iv_ff[127:64]  <= csr_wdata;
            CSR_IV_LOW:      iv_ff[63:0]    <= csr_wdata;
            CSR_CHAIN_MODE:  mode_ff        <= csr_wdata[1:0];
            CSR_DECRYPT_SEL: dec_ff         <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   abm_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (key_wr),
      .key        (key_ff),
      .round_keys (round_keys),
      .status     (ks_status)
   );

   // handshakes: the word in the input register moves on when the result
   // register is empty or being drained
   assign advance      = in_v_ff && (!out_v_ff || rsp_ch.ready);
   assign req_ch.ready = !ks_status.busy && (!in_v_ff || advance);
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (take) begin
         in_v_ff <= 1'b1;
      end else if (advance) begin
         in_v_ff <= 1'b0;
      end
      if (take) begin
         in_data_ff  <= {req_ch.block_high, req_ch.block_low};
         in_first_ff <= req_ch.first_block;
      end
   end

   // datapath
   assign is_cbc    = (mode_ff == MODE_CBC);
   assign is_ctr    = (mode_ff == MODE_CTR);
   assign chain_eff = in_first_ff ? iv_ff : chain_ff;
   assign ctr_eff   = in_first_ff ? iv_ff : ctr_ff;

   always_comb begin
      if (is_cbc) begin
         fwd_in = in_data_ff ^ chain_eff;
      end else if (is_ctr) begin
         fwd_in = ctr_eff;
      end else begin
         fwd_in = in_data_ff;
      end
   end

   abm_cipher u_cipher (
      .round_keys (round_keys),
      .fwd_in     (fwd_in),
      .inv_in     (in_data_ff),
      .fwd_out    (fwd_out),
      .inv_out    (inv_out)
   );

   always_comb begin
      if (is_cbc) begin
         out_data_in = dec_ff ? (inv_out ^ chain_eff) : fwd_out;
      end else if (is_ctr) begin
         out_data_in = in_data_ff ^ fwd_out;
      end else begin
         out_data_in = dec_ff ? inv_out : fwd_out;
      end
   end

   // chaining block and counter follow each word as it leaves
   always_comb begin
      chain_in = chain_ff;
      ctr_in   = ctr_ff;
      if (advance) begin
         chain_in = chain_eff;
         ctr_in   = ctr_eff;
         if (is_cbc) begin
            chain_in = dec_ff ? in_data_ff : fwd_out;
         end else if (is_ctr) begin
            ctr_in = ctr_eff + BLOCK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
         ctr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         ctr_ff   <= ctr_in;
         if (advance) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.result_high = out_data_ff[127:64];
   assign rsp_ch.result_low  = out_data_ff[63:0];

`ifndef SYNTHESIS
   // no word is taken while the key schedule is being rebuilt
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      ks_status.busy |-> !req_ch.ready)
      else $error("word accepted during key expansion");

   // a key write always restarts the expansion
   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> ks_status.busy && !ks_status.done)
      else $error("key write did not restart expansion");

   // accepting a word never overwrites one that cannot move on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      take |-> !(in_v_ff && !advance))
      else $error("input register overrun");

   // a word that advances always appears as a result next cycle
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_v_ff)
      else $error("advanced word lost");
`endif

endmodule

@@ dv/aes128_block_modes_unit_test.sv @@
`timescale 1ns / 1ps
// checks the aes-128 ecb/cbc/ctr unit against a behavioral cipher model kept
// in this bench, with random idling on both channels and a long result stall
module aes128_block_modes_unit_test;
   import abm_pkg::*;

   typedef struct packed {
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
   } block_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [HALF_W-1:0] csr_wdata;

   abm_req_if req_ch ();
   abm_rsp_if rsp_ch ();

   aes128_block_modes_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model state
   logic [7:0] fwd_box [0:255];
   logic [7:0] inv_box [0:255];
   logic [31:0] sched [0:43];
   logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
   logic [1:0] mode_q;
   logic dec_q;
   logic [127:0] chain_q, ctr_q;

   block_type expected_blocks [$];
   int errors;
   int cycle_count;
   int stall_hold;
   bit idle_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // generous bound: ~600 words, long gaps, stalls, key expansions
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic void build_schedule();
      logic [7:0] rc [0:9];
      logic [31:0] t;
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      sched[0] = key_hi_q[63:32];
      sched[1] = key_hi_q[31:0];
      sched[2] = key_lo_q[63:32];
      sched[3] = key_lo_q[31:0];
      for (int i = 4; i < 44; i++) begin
         t = sched[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
            t ^= {rc[i/4-1], 24'h0};
         end
         sched[i] = sched[i-4] ^ t;
      end
   endfunction

   // state byte n = column n/4, row n%4, msb first
   function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
      return s ^ {sched[rnd*4], sched[rnd*4+1], sched[rnd*4+2], sched[rnd*4+3]};
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inv);
      logic [7:0] a [0:15];
      logic [127:0] o;
      for (int n = 0; n < 16; n++) a[n] = s[127-8*n -: 8];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv) o[127-8*(((c+r)%4)*4+r) -: 8] = inv_box[a[c*4+r]];
            else o[127-8*(c*4+r) -: 8] = fwd_box[a[((c+r)%4)*4+r]];
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
      logic [7:0] m [0:15];
      logic [7:0] col [0:3];
      logic [7:0] acc;
      logic [127:0] o;
      if (inv) m = '{14, 11, 13, 9, 9, 14, 11, 13, 13, 9, 14, 11, 11, 13, 9, 14};
      else m = '{2, 3, 1, 1, 1, 2, 3, 1, 1, 1, 2, 3, 3, 1, 1, 2};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = s[127-8*(c*4+k) -: 8];
         for (int j = 0; j < 4; j++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_times(m[j*4+k], col[k]);
            o[127-8*(c*4+j) -: 8] = acc;
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] encipher(input logic [127:0] s);
      s = add_key(s, 0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
         s = sub_shift(s, 1'b0);
         if (rnd < 10) s = mix(s, 1'b0);
         s = add_key(s, rnd);
      end
      return s;
   endfunction

   function automatic logic [127:0] decipher(input logic [127:0] s);
      s = add_key(s, 10);
      for (int rnd = 9; rnd >= 0; rnd--) begin
         s = sub_shift(s, 1'b1);
         s = add_key(s, rnd);
         if (rnd > 0) s = mix(s, 1'b1);
      end
      return s;
   endfunction

   // next output word of the chained cipher, advancing chain and counter
   function automatic logic [127:0] cipher_word(input logic [127:0] din, input bit first);
      logic [127:0] r;
      if (first) begin
         chain_q = {iv_hi_q, iv_lo_q};
         ctr_q = {iv_hi_q, iv_lo_q};
      end
      if (mode_q == MODE_CBC) begin
         if (dec_q) begin
            r = decipher(din) ^ chain_q;
            chain_q = din;
         end else begin
            r = encipher(din ^ chain_q);
            chain_q = r;
         end
      end else if (mode_q == MODE_CTR) begin
         r = din ^ encipher(ctr_q);
         ctr_q = ctr_q + 128'd1;
      end else begin
         r = dec_q ? decipher(din) : encipher(din);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   // result side: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_rsp) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      block_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected result word", rsp_ch.result_high, 64'h0);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_ch.result_high !== want.hi)
               report_mismatch("result_high", rsp_ch.result_high, want.hi);
            if (rsp_ch.result_low !== want.lo)
               report_mismatch("result_low", rsp_ch.result_low, want.lo);
         end
      end
   end

   // write one register, mirror it in the model
   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KEY_HIGH: begin key_hi_q = value; build_schedule(); end
         CSR_KEY_LOW: begin key_lo_q = value; build_schedule(); end
         CSR_IV_HIGH: iv_hi_q = value;
         CSR_IV_LOW: iv_lo_q = value;
         CSR_CHAIN_MODE: mode_q = value[1:0];
         CSR_DECRYPT_SEL: dec_q = value[0];
         default: ;
      endcase
   endtask

   // offer one word, wait for acceptance, queue its expected result;
   // valid stays up after acceptance so the next word can follow directly
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit first,
                             input bit gaps);
      block_type want;
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.block_high <= hi;
      req_ch.block_low <= lo;
      req_ch.first_block <= first;
      do @(posedge clock); while (!req_ch.ready);
      want = cipher_word({hi, lo}, first);
      expected_blocks.push_back(want);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_all(input logic [63:0] kh, input logic [63:0] kl,
                          input logic [63:0] ih, input logic [63:0] il,
                          input logic [63:0] mode, input logic [63:0] dec);
      write_csr(CSR_KEY_HIGH, kh);
      write_csr(CSR_KEY_LOW, kl);
      write_csr(CSR_IV_HIGH, ih);
      write_csr(CSR_IV_LOW, il);
      write_csr(CSR_CHAIN_MODE, mode);
      write_csr(CSR_DECRYPT_SEL, dec);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // reset key, no first block: cbc chains from zero, ctr counts from zero
   task automatic test_reset_state();
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      send_block('1, '1, 1'b0, 1'b0);
      wait_drained();
      write_csr(CSR_CHAIN_MODE, MODE_CBC);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
      wait_drained();
      write_csr(CSR_CHAIN_MODE, MODE_CTR);
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      wait_drained();
   endtask

   // fips-197 vector, both directions, every mode, the unused mode code
   task automatic test_directed_modes();
      set_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'hffffffffffffffff, 64'hfffffffffffffffe, MODE_ECB, 0);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
      wait_drained();
      write_csr(CSR_DECRYPT_SEL, 1);
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0, 1'b0);
      wait_drained();
      write_csr(CSR_CHAIN_MODE, 3);
      send_block('1, 64'h0, 1'b0, 1'b0);
      wait_drained();
      write_csr(CSR_CHAIN_MODE, MODE_CBC);
      for (int i = 0; i < 3; i++) send_block(rand64(), rand64(), i == 0, 1'b0);
      wait_drained();
      write_csr(CSR_DECRYPT_SEL, 64'hfffffffffffffffe);
      for (int i = 0; i < 3; i++) send_block(rand64(), rand64(), i == 0, 1'b0);
      wait_drained();
      // counter wraps from all ones through the low half carry
      write_csr(CSR_CHAIN_MODE, MODE_CTR);
      for (int i = 0; i < 4; i++) send_block(rand64(), rand64(), i == 0, 1'b0);
      wait_drained();
      write_csr(CSR_IV_LOW, '1);
      write_csr(CSR_IV_HIGH, 64'h0);
      for (int i = 0; i < 3; i++) send_block(rand64(), rand64(), i == 0, 1'b0);
      wait_drained();
      // index beyond the map is ignored
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= 3'd7;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      wait_drained();
   endtask

   // random streams per setting, chained or not, with random restarts
   task automatic test_random_streams(input int words);
      int sent;
      sent = 0;
      while (sent < words) begin
         set_all(rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 3),
                 $urandom_range(0, 1));
         for (int i = 0; i < 40; i++) begin
            send_block(rand64(), rand64(), (i == 0) || ($urandom_range(0, 15) == 0), 1'b1);
            sent++;
         end
         wait_drained();
      end
   endtask

   // long result stall while the sender keeps offering, then a run with results always taken
   task automatic test_backpressure();
      set_all(rand64(), rand64(), rand64(), rand64(), MODE_CBC, 0);
      stall_hold <= 200;
      for (int i = 0; i < 30; i++) send_block(rand64(), rand64(), i == 0, 1'b0);
      wait_drained();
      idle_rsp = 1'b1;
      for (int i = 0; i < 30; i++) send_block(rand64(), rand64(), 1'b0, 1'b0);
      idle_rsp = 1'b0;
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         fwd_box[i] = SBOX_TAB[i];
         inv_box[SBOX_TAB[i]] = 8'(i);
      end
      errors = 0;
      cycle_count = 0;
      stall_hold = 0;
      idle_rsp = 1'b0;
      key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
      mode_q = MODE_ECB; dec_q = 1'b0;
      chain_q = '0; ctr_q = '0;
      build_schedule();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.block_high = '0;
      req_ch.block_low = '0;
      req_ch.first_block = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_modes();
      test_backpressure();
      test_random_streams(480);

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
